/* hw/rtl/brle_pkg.sv */
`default_nettype none

package brle_pkg;

  localparam int unsigned WordBits = 8;
  localparam int unsigned LenBits  = 7;
  localparam int unsigned MaxCodes = WordBits;
  localparam int unsigned CntBits  = $clog2(MaxCodes + 1);

  localparam logic [LenBits-1:0] MaxRun = 7'd127;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [LenBits-1:0]  len_t;
  typedef logic [CntBits-1:0]  cnt_t;

endpackage

`default_nettype wire

/* hw/rtl/bit_run_length_encoder_core.sv */
// Channel  Direction  Handshake               Payload
// input    in         in_valid_i, in_stall_o  data_byte_i, flush_i
// output   out        out_valid_o, out_stall_i run_code_o, last_of_item_o
//
// An accepted word is held in the input register, then the whole byte is encoded
// in one pass into an eight-entry result buffer that drains one code a cycle while the output is not stalled.
// A byte may yield no codes at all or up to eight, and all of them leave
// through the single output port, which sets the rate.
// The next word is taken while codes of the previous one are still being delivered.
// Reset clears the pending run and both buffers; a stalled output holds its code.
`default_nettype none

module bit_run_length_encoder_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire brle_pkg::word_t data_byte_i,
  input  wire logic           flush_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output brle_pkg::word_t     run_code_o,
  output logic                last_of_item_o
);
  import brle_pkg::*;

  logic  in_valid_q, in_valid_d;
  word_t data_q;
  logic  flush_q;

  logic  active_q, active_d;
  logic  bit_q, bit_d;
  len_t  len_q, len_d;

  word_t codes_q [MaxCodes];
  word_t codes_d [MaxCodes];
  word_t new_codes [MaxCodes];
  cnt_t  cnt_q, cnt_d, new_cnt;

  logic  buf_free, process, in_accept, out_pop;

  assign out_pop    = out_valid_o && !out_stall_i;
  assign buf_free   = (cnt_q == '0) || ((cnt_q == cnt_t'(1)) && !out_stall_i);
  assign process    = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !process;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o    = (cnt_q != '0);
  assign run_code_o     = codes_q[0];
  assign last_of_item_o = (cnt_q == cnt_t'(1));

  always_comb begin
    logic a;
    logic b;
    len_t l;
    cnt_t n;
    a = active_q;
    b = bit_q;
    l = len_q;
    n = '0;
    for (int k = 0; k < MaxCodes; k++) begin
      new_codes[k] = '0;
    end
    if (flush_q) begin
      if (a) begin
        new_codes[0] = {b, l};
        n = cnt_t'(1);
      end
      a = 1'b0;
      b = 1'b0;
      l = '0;
    end else begin
      for (int i = WordBits - 1; i >= 0; i--) begin
        if (a && (data_q[i] == b) && (l < MaxRun)) begin
          l = l + len_t'(1);
        end else begin
          if (a) begin
            new_codes[n[CntBits-2:0]] = {b, l};
            n = n + cnt_t'(1);
          end
          a = 1'b1;
          b = data_q[i];
          l = len_t'(1);
        end
      end
    end
    new_cnt  = n;
    active_d = process ? a : active_q;
    bit_d    = process ? b : bit_q;
    len_d    = process ? l : len_q;
  end

  always_comb begin
    in_valid_d = in_accept ? 1'b1 : (process ? 1'b0 : in_valid_q);
    cnt_d      = cnt_q;
    for (int k = 0; k < MaxCodes; k++) begin
      codes_d[k] = codes_q[k];
    end
    if (process) begin
      cnt_d = new_cnt;
      for (int k = 0; k < MaxCodes; k++) begin
        codes_d[k] = new_codes[k];
      end
    end else if (out_pop) begin
      cnt_d = cnt_q - cnt_t'(1);
      for (int k = 0; k < MaxCodes - 1; k++) begin
        codes_d[k] = codes_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      active_q   <= 1'b0;
      bit_q      <= 1'b0;
      len_q      <= '0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      active_q   <= active_d;
      bit_q      <= bit_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q  <= data_byte_i;
      flush_q <= flush_i;
    end
    codes_q <= codes_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/brle_checker.sv */
`default_nettype none

module brle_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_i,
  input wire logic                 out_stall_i,
  input wire brle_pkg::word_t      run_code_i,
  input wire logic                 last_of_item_i
);
  import brle_pkg::*;

  logic out_pop;
  assign out_pop = out_valid_i && !out_stall_i;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("Output valid dropped while stalled.");

  a_hold_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(run_code_i) && $stable(last_of_item_i))
    else $error("Stalled output word changed.");

  a_item_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pop && !last_of_item_i |=> out_valid_i)
    else $error("Codes of one input word were not delivered back to back.");

  a_bit_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pop && !last_of_item_i && (run_code_i[LenBits-1:0] != MaxRun)
    |=> run_code_i[WordBits-1] != $past(run_code_i[WordBits-1]))
    else $error("A short run was followed by a run of the same bit.");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> run_code_i[LenBits-1:0] != '0)
    else $error("Code with zero run length.");

endmodule

bind bit_run_length_encoder_core brle_checker u_brle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .run_code_i     (run_code_o),
  .last_of_item_i (last_of_item_o)
);

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brle_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned LongHold      = 80;

  typedef struct packed {
    word_t code;
    logic  last;
  } run_code_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid = 1'b0;
  word_t in_data = '0;
  logic  in_flush = 1'b0;
  logic  out_stall = 1'b0;
  logic  in_stall_o;
  logic  out_valid_o;
  word_t run_code_o;
  logic  last_of_item_o;

  run_code_t   pending_codes[$];
  run_code_t   head_code;
  logic        run_pending = 1'b0;
  logic        cur_bit = 1'b0;
  len_t        cur_len = '0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_burst = 0;
  bit          quiet = 1'b0;

  bit_run_length_encoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (in_data),
    .flush_i       (in_flush),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .run_code_o    (run_code_o),
    .last_of_item_o(last_of_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_codes(input word_t data, input logic flush);
    run_code_t codes[$];
    run_code_t one;
    logic      b;
    if (flush) begin
      if (run_pending) begin
        one.code = {cur_bit, cur_len};
        one.last = 1'b0;
        codes.push_back(one);
      end
      run_pending = 1'b0;
      cur_bit     = 1'b0;
      cur_len     = '0;
    end else begin
      for (int pos = WordBits - 1; pos >= 0; pos--) begin
        b = data[pos];
        if (run_pending && b == cur_bit && cur_len < MaxRun) begin
          cur_len = cur_len + 1'b1;
        end else begin
          if (run_pending) begin
            one.code = {cur_bit, cur_len};
            one.last = 1'b0;
            codes.push_back(one);
          end
          run_pending = 1'b1;
          cur_bit     = b;
          cur_len     = len_t'(1);
        end
      end
    end
    if (codes.size() != 0) codes[codes.size() - 1].last = 1'b1;
    foreach (codes[i]) pending_codes.push_back(codes[i]);
  endfunction

  task automatic send_word(input word_t data, input logic flush);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= data;
    in_flush <= flush;
    do @(posedge clk_i); while (in_stall_o);
    predict_codes(data, flush);
  endtask

  initial begin
    int unsigned n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_burst != 0) begin
        out_stall <= 1'b1;
        repeat (stall_burst) @(posedge clk_i);
        stall_burst = 0;
      end
      n = quiet ? 0 : $urandom_range(0, 4);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected word: run_code %02h last_of_item %0b", run_code_o, last_of_item_o);
        err_cnt++;
      end else begin
        head_code = pending_codes.pop_front();
        if (run_code_o !== head_code.code) begin
          $error("run_code: expected %02h, actual %02h", head_code.code, run_code_o);
          err_cnt++;
        end
        if (last_of_item_o !== head_code.last) begin
          $error("last_of_item: expected %0b, actual %0b", head_code.last, last_of_item_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h3C, 1'b1);
    send_word(8'hFF, 1'b1);
    // A full run of ones ending on a byte boundary, then closed by another one.
    send_word(8'h7F, 1'b0);
    repeat (15) send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    repeat (30) send_word(word_t'($urandom), 1'b0);
    send_word(word_t'($urandom), 1'b1);
    repeat (10) send_word(word_t'($urandom), $urandom_range(0, 3) == 0);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    stall_burst = LongHold;
    for (int i = 0; i < 24; i++) send_word((i % 2 == 0) ? 8'h55 : 8'hAA, 1'b0);
    send_word(8'h00, 1'b1);
    quiet = 1'b0;
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned mode;
    word_t       b;
    logic        fill;
    sent = 0;
    while (sent < n_items) begin
      len  = $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
      fill = 1'($urandom_range(0, 1));
      quiet = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: b = word_t'($urandom);
          1: b = ($urandom_range(0, 99) < 85) ? {WordBits{fill}} : word_t'($urandom);
          2: b = word_t'($urandom & $urandom & $urandom);
          default: b = word_t'($urandom | $urandom | $urandom);
        endcase
        if ($urandom_range(0, 29) == 0) begin
          send_word(word_t'($urandom), 1'b1);
          sent++;
        end
        send_word(b, 1'b0);
        sent++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_word(word_t'($urandom), 1'b1);
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_codes.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    test_backpressure();
    test_random_streams(340);
    finish_run();
  end

endmodule

`default_nettype wire

/* bit_run_length_encoder_core.f */
hw/rtl/brle_pkg.sv
hw/rtl/bit_run_length_encoder_core.sv
hw/rtl/brle_checker.sv
tb/sv/tb.sv
